// ----- rtl/hpgs_pkg.sv -----
// ----------------------------------------------------------------------------
// hpgs_pkg
// Shared types and constants for the host pc to guest state search block.
// ----------------------------------------------------------------------------
package hpgs_pkg;

  localparam int START_WORDS_DEF = 2;
  localparam int VALUE_BITS_DEF  = 64;
  localparam int MAX_ROWS        = 512;

  localparam int WORD_W    = 64;
  localparam int OUT_WORDS = 4;
  localparam int ROW_W     = 10;
  localparam int ADJ_W     = 4;
  localparam int COL_W     = 3;
  localparam int SHIFT_W   = 7;
  localparam int CFG_IDX_W = 3;
  localparam int STATUS_W  = 2;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 272;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_GUEST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_HOST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCHED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADJUST      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 3'd4;

  localparam logic [ADJ_W-1:0] ADJUST_RESET = 4'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BEFORE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd2;

  // LEB128 byte fields
  localparam logic [7:0] LEB_PAYLOAD = 8'h7f;
  localparam logic [7:0] LEB_SIGN    = 8'h40;
  localparam logic [7:0] LEB_CONT    = 8'h80;
  localparam logic [SHIFT_W-1:0] LEB_STEP = 7'd7;

  typedef struct packed {
    logic [WORD_W-1:0] start_guest;
    logic [WORD_W-1:0] start_host;
    logic [WORD_W-1:0] target;     // searched pc minus adjust
    logic [ROW_W-1:0]  rows;
  } cfg_t;

  typedef struct packed {
    logic              complete;
    logic [WORD_W-1:0] delta;      // sign-extended to 64 bits
  } dec_t;

  typedef struct packed {
    logic [OUT_WORDS-1:0][WORD_W-1:0] word;
    logic [ROW_W-1:0]                 row_index;
    logic [STATUS_W-1:0]              status;
  } res_t;

endpackage

// ----- rtl/hpgs_cfg.sv -----
// ----------------------------------------------------------------------------
// hpgs_cfg
// Configuration registers; keeps the adjusted search target precomputed.
// ----------------------------------------------------------------------------
module hpgs_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hpgs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hpgs_pkg::WORD_W-1:0]      cfg_data,
  output hpgs_pkg::cfg_t                   cfg
);

  logic [hpgs_pkg::WORD_W-1:0] start_guest;
  logic [hpgs_pkg::WORD_W-1:0] start_host;
  logic [hpgs_pkg::WORD_W-1:0] searched, searched_next;
  logic [hpgs_pkg::ADJ_W-1:0]  adjust, adjust_next;
  logic [hpgs_pkg::ROW_W-1:0]  rows;
  logic [hpgs_pkg::WORD_W-1:0] target;
  logic                        wr;

  assign cfg_ready = 1'b1;
  assign wr = cfg_valid & cfg_ready;

  always_comb begin
    searched_next = searched;
    adjust_next   = adjust;
    if (wr && cfg_index == hpgs_pkg::REG_SEARCHED) begin
      searched_next = cfg_data;
    end
    if (wr && cfg_index == hpgs_pkg::REG_ADJUST) begin
      adjust_next = cfg_data[hpgs_pkg::ADJ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_guest <= '0;
      start_host  <= '0;
      searched    <= '0;
      adjust      <= hpgs_pkg::ADJUST_RESET;
      rows        <= '0;
      target      <= '0 - hpgs_pkg::WORD_W'(hpgs_pkg::ADJUST_RESET);
    end else begin
      searched <= searched_next;
      adjust   <= adjust_next;
      target   <= searched_next - hpgs_pkg::WORD_W'(adjust_next);
      if (wr && cfg_index == hpgs_pkg::REG_START_GUEST) begin
        start_guest <= cfg_data;
      end
      if (wr && cfg_index == hpgs_pkg::REG_START_HOST) begin
        start_host <= cfg_data;
      end
      if (wr && cfg_index == hpgs_pkg::REG_ROW_COUNT) begin
        rows <= cfg_data[hpgs_pkg::ROW_W-1:0];
      end
    end
  end

  assign cfg.start_guest = start_guest;
  assign cfg.start_host  = start_host;
  assign cfg.target      = target;
  assign cfg.rows        = rows;

endmodule

// ----- rtl/hpgs_leb_dec.sv -----
// ----------------------------------------------------------------------------
// hpgs_leb_dec
// One step of signed LEB128 decoding: merges a byte into the partial value
// and, on the final byte, sign-extends the value to 64 bits.
// ----------------------------------------------------------------------------
module hpgs_leb_dec #(
  parameter int VALUE_BITS = hpgs_pkg::VALUE_BITS_DEF
) (
  input  logic [7:0]                      byte_in,
  input  logic [VALUE_BITS-1:0]           partial,
  input  logic [hpgs_pkg::SHIFT_W-1:0]    shift,
  output logic [VALUE_BITS-1:0]           partial_next,
  output logic [hpgs_pkg::SHIFT_W-1:0]    shift_next,
  output hpgs_pkg::dec_t                  dec
);

  localparam int WIDE_W = VALUE_BITS + 7;

  logic                          active;
  logic [WIDE_W-1:0]             ins;
  logic [VALUE_BITS-1:0]         val;
  logic [VALUE_BITS-1:0]         ext;
  logic [hpgs_pkg::SHIFT_W-1:0]  sh;

  assign active = shift < hpgs_pkg::SHIFT_W'(VALUE_BITS);
  assign ins    = WIDE_W'(byte_in & hpgs_pkg::LEB_PAYLOAD) << shift;
  assign val    = active ? (partial | ins[VALUE_BITS-1:0]) : partial;
  assign sh     = active ? (shift + hpgs_pkg::LEB_STEP) : shift;

  always_comb begin
    ext = val;
    if (sh < hpgs_pkg::SHIFT_W'(VALUE_BITS) && (byte_in & hpgs_pkg::LEB_SIGN) != 8'd0) begin
      ext = val | ({VALUE_BITS{1'b1}} << sh);
    end
  end

  assign dec.complete = (byte_in & hpgs_pkg::LEB_CONT) == 8'd0;
  assign dec.delta    = hpgs_pkg::WORD_W'($signed(ext));
  assign partial_next = dec.complete ? '0 : val;
  assign shift_next   = dec.complete ? '0 : sh;

endmodule

// ----- rtl/hpgs_search.sv -----
// ----------------------------------------------------------------------------
// hpgs_search
// Search state: decoder registers, guest and host accumulators, row counter
// and the result register.
// ----------------------------------------------------------------------------
module hpgs_search #(
  parameter int START_WORDS = hpgs_pkg::START_WORDS_DEF,
  parameter int VALUE_BITS  = hpgs_pkg::VALUE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  hpgs_pkg::cfg_t  cfg,
  input  logic            step,
  input  logic [7:0]      byte_in,
  input  logic            first_in,
  input  logic            res_ready,
  output logic            res_valid,
  output hpgs_pkg::res_t  res
);

  logic [VALUE_BITS-1:0]         guest [START_WORDS];
  logic [VALUE_BITS-1:0]         guest_next [START_WORDS];
  logic [VALUE_BITS-1:0]         cur_guest [START_WORDS];
  logic [hpgs_pkg::WORD_W-1:0]   host, host_next, cur_host, host_sum;
  logic [VALUE_BITS-1:0]         partial, partial_next, cur_partial, dec_partial;
  logic [hpgs_pkg::SHIFT_W-1:0]  shift, shift_next, cur_shift, dec_shift;
  logic [hpgs_pkg::COL_W-1:0]    col, col_next, cur_col;
  logic [hpgs_pkg::ROW_W-1:0]    row, row_next, cur_row, row_inc;
  logic                          done, done_next;
  logic                          emit;
  hpgs_pkg::res_t                res_next;
  hpgs_pkg::dec_t                dec;

  always_comb begin
    for (int j = 0; j < START_WORDS; j++) begin
      if (!first_in) begin
        cur_guest[j] = guest[j];
      end else if (j == 0) begin
        cur_guest[j] = cfg.start_guest[VALUE_BITS-1:0];
      end else begin
        cur_guest[j] = '0;
      end
    end
    cur_host    = first_in ? cfg.start_host : host;
    cur_partial = first_in ? '0 : partial;
    cur_shift   = first_in ? '0 : shift;
    cur_col     = first_in ? '0 : col;
    cur_row     = first_in ? '0 : row;
  end

  hpgs_leb_dec #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dec (
    .byte_in      (byte_in),
    .partial      (cur_partial),
    .shift        (cur_shift),
    .partial_next (dec_partial),
    .shift_next   (dec_shift),
    .dec          (dec)
  );

  assign host_sum = cur_host + dec.delta;
  assign row_inc  = cur_row + hpgs_pkg::ROW_W'(1);

  always_comb begin
    guest_next   = cur_guest;
    host_next    = cur_host;
    partial_next = cur_partial;
    shift_next   = cur_shift;
    col_next     = cur_col;
    row_next     = cur_row;
    done_next    = first_in ? 1'b0 : done;
    emit         = 1'b0;
    res_next.status    = hpgs_pkg::ST_NO_MATCH;
    res_next.row_index = cfg.rows;
    res_next.word      = '0;

    priority if (first_in && cfg.target < cfg.start_host) begin
      done_next       = 1'b1;
      emit            = 1'b1;
      res_next.status = hpgs_pkg::ST_BEFORE;
    end else if (first_in && cfg.rows == '0) begin
      done_next = 1'b1;
      emit      = 1'b1;
    end else if (done_next) begin
      // search over: byte dropped
    end else begin
      partial_next = dec_partial;
      shift_next   = dec_shift;
      if (dec.complete) begin
        if (cur_col < hpgs_pkg::COL_W'(START_WORDS)) begin
          for (int j = 0; j < START_WORDS; j++) begin
            if (cur_col == hpgs_pkg::COL_W'(j)) begin
              guest_next[j] = cur_guest[j] + dec.delta[VALUE_BITS-1:0];
            end
          end
          col_next = cur_col + hpgs_pkg::COL_W'(1);
        end else begin
          host_next = host_sum;
          col_next  = '0;
          if (host_sum > cfg.target) begin
            done_next          = 1'b1;
            emit               = 1'b1;
            res_next.status    = hpgs_pkg::ST_FOUND;
            res_next.row_index = cur_row;
            for (int j = 0; j < START_WORDS; j++) begin
              res_next.word[j] = hpgs_pkg::WORD_W'(cur_guest[j]);
            end
          end else begin
            row_next = row_inc;
            if (32'(row_inc) >= 32'(cfg.rows) || 32'(row_inc) >= 32'(hpgs_pkg::MAX_ROWS)) begin
              done_next = 1'b1;
              emit      = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < START_WORDS; j++) begin
        guest[j] <= '0;
      end
      host      <= '0;
      partial   <= '0;
      shift     <= '0;
      col       <= '0;
      row       <= '0;
      done      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (step) begin
        guest   <= guest_next;
        host    <= host_next;
        partial <= partial_next;
        shift   <= shift_next;
        col     <= col_next;
        row     <= row_next;
        done    <= done_next;
      end
      if (step && emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      res <= res_next;
    end
  end

  a_emit_ends_search: assert property (@(posedge clk) disable iff (rst)
    step && emit |=> done)
    else $error("result issued without ending the search");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    32'(col) <= START_WORDS)
    else $error("column index past host column");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    !done |-> 32'(row) < 32'(hpgs_pkg::MAX_ROWS))
    else $error("row counter past table bound while searching");

  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    step && done && !first_in |=> !$rose(res_valid) && $stable(host))
    else $error("activity after search ended");

endmodule

// ----- rtl/host_pc_to_guest_state_search.sv -----
// ----------------------------------------------------------------------------
// host_pc_to_guest_state_search
// Decodes a delta-encoded signed LEB128 search table and reports the guest
// words of the first row whose host end passes the adjusted searched pc.
// ----------------------------------------------------------------------------
// Throughput: one table byte per cycle; input stalls only while a result waits
//   on m_tready.
// Result path: the last byte passes through the input register, then the
//   result register, before its result is on m_tdata.
// Reset: clears decoder, accumulators, row counter and result valid; registers
//   return to their reset values (search_adjust = 2, others 0).
module host_pc_to_guest_state_search #(
  parameter int START_WORDS = hpgs_pkg::START_WORDS_DEF,
  parameter int VALUE_BITS  = hpgs_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [hpgs_pkg::IN_DATA_W-1:0]      s_tdata,   // byte_value
  input  logic [0:0]                          s_tuser,   // first_byte
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // status[1:0], row_index[11:2], guest_word0..3 [267:12], zero pad
  output logic [hpgs_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hpgs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hpgs_pkg::WORD_W-1:0]         cfg_data
);

  hpgs_pkg::cfg_t cfg;
  hpgs_pkg::res_t res;
  logic           in_vld;
  logic [7:0]     in_byte;
  logic           in_first;
  logic           advance;
  logic           step;

  hpgs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_vld || advance;
  assign step     = in_vld && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_first <= s_tuser[0];
    end
  end

  hpgs_search #(
    .START_WORDS (START_WORDS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_search (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .byte_in   (in_byte),
    .first_in  (in_first),
    .res_ready (m_tready),
    .res_valid (m_tvalid),
    .res       (res)
  );

  assign m_tdata = hpgs_pkg::OUT_DATA_W'(res);

endmodule
